@@ design/lattice_boltzmann_d3q19_cell_collide_defines.svh @@
// assertion helpers for the cell collision block
`ifndef LATTICE_BOLTZMANN_D3Q19_CELL_COLLIDE_DEFINES_SVH
`define LATTICE_BOLTZMANN_D3Q19_CELL_COLLIDE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LBMC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LBMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/lbmc_pkg.sv @@
package lbmc_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 28;
	localparam int LANE_W          = 32;
	localparam int CFG_W           = 32;
	localparam int RATE_W          = 30;
	localparam int IDX_W           = 3;
	localparam int NUM_PAIRS       = 9;
	localparam int NUM_DIRS        = 19;
	localparam int STAGES          = 12;

	typedef enum logic [1:0] {
		KIND_FLUID    = 2'd0,
		KIND_OBSTACLE = 2'd1,
		KIND_INJECT   = 2'd2,
		KIND_GHOST    = 2'd3
	} kind_t;

	localparam logic [IDX_W-1:0] REG_RELAX      = 3'd0;
	localparam logic [IDX_W-1:0] REG_DRIVE      = 3'd1;
	localparam logic [IDX_W-1:0] REG_GRAV_X     = 3'd2;
	localparam logic [IDX_W-1:0] REG_GRAV_Y     = 3'd3;
	localparam logic [IDX_W-1:0] REG_GRAV_Z     = 3'd4;
	localparam logic [IDX_W-1:0] REG_KEEP_RHO   = 3'd5;
	localparam logic [IDX_W-1:0] REG_KEEP_SPEED = 3'd6;

	// lattice directions of the odd-free half of each opposite pair
	localparam int DIR_X [NUM_PAIRS]    = '{1, 0, 1, 1, 1, 1, 0, 0, 0};
	localparam int DIR_Y [NUM_PAIRS]    = '{0, 1, 1, -1, 0, 0, 1, 1, 0};
	localparam int DIR_Z [NUM_PAIRS]    = '{0, 0, 0, 0, 1, -1, 1, -1, 1};
	localparam int DIR_AXIS [NUM_PAIRS] = '{1, 1, 0, 0, 0, 0, 0, 0, 1};

	typedef logic [STAGES:1] stage_vec_t;

	function automatic logic signed [63:0] sat(input logic signed [63:0] x, input int vw);
		logic signed [63:0] lim;
		lim = 64'sd1 <<< (vw - 1);
		if (x > lim - 64'sd1)
			return lim - 64'sd1;
		else if (x < -lim)
			return -lim;
		return x;
	endfunction

	// rounded product, ties up, then saturated
	function automatic logic signed [63:0] fmul(input logic signed [32:0] a,
		input logic signed [32:0] b, input int fb, input int vw);
		logic signed [65:0] p;
		p = a * b;
		p = p + (66'sd1 <<< (fb - 1));
		p = p >>> fb;
		return sat(p[63:0], vw);
	endfunction

	function automatic logic signed [63:0] term(input int e, input logic signed [63:0] v);
		if (e > 0)
			return v;
		else if (e < 0)
			return -v;
		return 64'sd0;
	endfunction

endpackage

@@ design/lbmc_moments.sv @@
module lbmc_moments #(
	parameter int VALUE_WIDTH = lbmc_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = lbmc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  lbmc_pkg::stage_vec_t          en,
	input  logic signed [VALUE_WIDTH-1:0] f_s1 [lbmc_pkg::NUM_DIRS],
	input  lbmc_pkg::kind_t               kind_s2,
	input  logic signed [VALUE_WIDTH-1:0] drive,
	output logic signed [VALUE_WIDTH-1:0] rho_s3,
	output logic signed [VALUE_WIDTH-1:0] vx_s3,
	output logic signed [VALUE_WIDTH-1:0] vy_s3,
	output logic signed [VALUE_WIDTH-1:0] vz_s3
);
	localparam logic signed [63:0] ONE_SAT =
		lbmc_pkg::sat(64'sd1 <<< FRAC_BITS, VALUE_WIDTH);

	logic signed [VALUE_WIDTH:0]   ps_s2 [lbmc_pkg::NUM_PAIRS];
	logic signed [VALUE_WIDTH:0]   d_s2 [lbmc_pkg::NUM_PAIRS];
	logic signed [VALUE_WIDTH-1:0] f18_s2;
	logic signed [63:0] rs, sx, sy, sz, rho_nx, vx_nx, vy_nx, vz_nx;

	// pair sums and differences first, then the totals
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < lbmc_pkg::NUM_PAIRS; k++) begin
				ps_s2[k] <= (VALUE_WIDTH+1)'(f_s1[2*k]) + (VALUE_WIDTH+1)'(f_s1[2*k+1]);
				d_s2[k]  <= (VALUE_WIDTH+1)'(f_s1[2*k]) - (VALUE_WIDTH+1)'(f_s1[2*k+1]);
			end
			f18_s2 <= f_s1[18];
		end
	end

	always_comb begin
		rs = 64'(f18_s2);
		sx = '0;
		sy = '0;
		sz = '0;
		for (int k = 0; k < lbmc_pkg::NUM_PAIRS; k++) begin
			rs = rs + 64'(ps_s2[k]);
			sx = sx + lbmc_pkg::term(lbmc_pkg::DIR_X[k], 64'(d_s2[k]));
			sy = sy + lbmc_pkg::term(lbmc_pkg::DIR_Y[k], 64'(d_s2[k]));
			sz = sz + lbmc_pkg::term(lbmc_pkg::DIR_Z[k], 64'(d_s2[k]));
		end
		rho_nx = lbmc_pkg::sat(rs, VALUE_WIDTH);
		vx_nx  = lbmc_pkg::sat(sx, VALUE_WIDTH);
		vy_nx  = lbmc_pkg::sat(sy, VALUE_WIDTH);
		vz_nx  = lbmc_pkg::sat(sz, VALUE_WIDTH);
		unique case (kind_s2)
			lbmc_pkg::KIND_INJECT: begin
				rho_nx = ONE_SAT;
				vx_nx  = 64'(drive);
				vy_nx  = '0;
				vz_nx  = '0;
			end
			lbmc_pkg::KIND_OBSTACLE: begin
				vx_nx = '0;
				vy_nx = '0;
				vz_nx = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			rho_s3 <= rho_nx[VALUE_WIDTH-1:0];
			vx_s3  <= vx_nx[VALUE_WIDTH-1:0];
			vy_s3  <= vy_nx[VALUE_WIDTH-1:0];
			vz_s3  <= vz_nx[VALUE_WIDTH-1:0];
		end
	end

endmodule

@@ design/lbmc_rest.sv @@
module lbmc_rest #(
	parameter int VALUE_WIDTH = lbmc_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = lbmc_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  lbmc_pkg::stage_vec_t            en,
	input  logic signed [VALUE_WIDTH-1:0]   f18_s1,
	input  logic signed [VALUE_WIDTH-1:0]   vx_s3,
	input  logic signed [VALUE_WIDTH-1:0]   vy_s3,
	input  logic signed [VALUE_WIDTH-1:0]   vz_s3,
	input  logic signed [VALUE_WIDTH-1:0]   rho_s5,
	input  logic [lbmc_pkg::RATE_W-1:0]     rate,
	input  lbmc_pkg::kind_t                 kind_s9,
	output logic signed [VALUE_WIDTH-1:0]   p_s6,
	output logic signed [VALUE_WIDTH-1:0]   rest_s12
);
	localparam longint W3 = ((64'sd1 <<< FRAC_BITS) + 1) / 3;
	localparam logic signed [32:0] W3_K  = 33'(W3);
	localparam logic signed [32:0] K15   = 33'(64'sd3 <<< (FRAC_BITS - 1));

	logic signed [VALUE_WIDTH-1:0] f18_s [2:9];
	logic signed [VALUE_WIDTH-1:0] sqx_s4, sqy_s4, sqz_s4, vel2_s5, d18_s8, m18_s9;
	logic signed [VALUE_WIDTH-1:0] pw3_s [7:9];
	logic signed [VALUE_WIDTH-1:0] n18_s [10:11];
	logic signed [32:0] rate_k;
	logic signed [63:0] sqx_nx, sqy_nx, sqz_nx, vel2_nx, p_nx, pw3_nx, d18_nx, m18_nx, n18_nx;

	assign rate_k = $signed({3'b000, rate});

	always_comb begin
		sqx_nx  = lbmc_pkg::fmul(33'(vx_s3), 33'(vx_s3), FRAC_BITS, VALUE_WIDTH);
		sqy_nx  = lbmc_pkg::fmul(33'(vy_s3), 33'(vy_s3), FRAC_BITS, VALUE_WIDTH);
		sqz_nx  = lbmc_pkg::fmul(33'(vz_s3), 33'(vz_s3), FRAC_BITS, VALUE_WIDTH);
		vel2_nx = lbmc_pkg::sat(64'(sqx_s4) + 64'(sqy_s4) + 64'(sqz_s4), VALUE_WIDTH);
		p_nx    = lbmc_pkg::sat(64'(rho_s5)
			- lbmc_pkg::fmul(33'(vel2_s5), K15, FRAC_BITS, VALUE_WIDTH), VALUE_WIDTH);
		pw3_nx  = lbmc_pkg::fmul(33'(p_s6), W3_K, FRAC_BITS, VALUE_WIDTH);
		d18_nx  = lbmc_pkg::sat(64'(pw3_s[7]) - 64'(f18_s[7]), VALUE_WIDTH);
		m18_nx  = lbmc_pkg::fmul(rate_k, 33'(d18_s8), FRAC_BITS, VALUE_WIDTH);
		unique case (kind_s9)
			lbmc_pkg::KIND_FLUID:
				n18_nx = lbmc_pkg::sat(64'(f18_s[9]) + 64'(m18_s9), VALUE_WIDTH);
			lbmc_pkg::KIND_OBSTACLE:
				n18_nx = 64'(f18_s[9]);
			default:
				n18_nx = 64'(pw3_s[9]);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[2])
			f18_s[2] <= f18_s1;
		for (int s = 3; s <= 9; s++)
			if (en[s])
				f18_s[s] <= f18_s[s-1];
		if (en[4]) begin
			sqx_s4 <= sqx_nx[VALUE_WIDTH-1:0];
			sqy_s4 <= sqy_nx[VALUE_WIDTH-1:0];
			sqz_s4 <= sqz_nx[VALUE_WIDTH-1:0];
		end
		if (en[5])
			vel2_s5 <= vel2_nx[VALUE_WIDTH-1:0];
		if (en[6])
			p_s6 <= p_nx[VALUE_WIDTH-1:0];
		if (en[7])
			pw3_s[7] <= pw3_nx[VALUE_WIDTH-1:0];
		if (en[8]) begin
			pw3_s[8] <= pw3_s[7];
			d18_s8   <= d18_nx[VALUE_WIDTH-1:0];
		end
		if (en[9]) begin
			pw3_s[9] <= pw3_s[8];
			m18_s9   <= m18_nx[VALUE_WIDTH-1:0];
		end
		if (en[10])
			n18_s[10] <= n18_nx[VALUE_WIDTH-1:0];
		if (en[11])
			n18_s[11] <= n18_s[10];
		if (en[12])
			rest_s12 <= n18_s[11];
	end

endmodule

@@ design/lbmc_pair.sv @@
module lbmc_pair #(
	parameter int VALUE_WIDTH = lbmc_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = lbmc_pkg::FRAC_BITS_DEF,
	parameter int EX          = 1,
	parameter int EY          = 0,
	parameter int EZ          = 0,
	parameter int AXIS        = 1
) (
	input  logic                          clk,
	input  lbmc_pkg::stage_vec_t          en,
	input  logic signed [VALUE_WIDTH-1:0] fp_s1,
	input  logic signed [VALUE_WIDTH-1:0] fn_s1,
	input  logic signed [VALUE_WIDTH-1:0] vx_s3,
	input  logic signed [VALUE_WIDTH-1:0] vy_s3,
	input  logic signed [VALUE_WIDTH-1:0] vz_s3,
	input  logic signed [VALUE_WIDTH-1:0] g0,
	input  logic signed [VALUE_WIDTH-1:0] g1,
	input  logic signed [VALUE_WIDTH-1:0] g2,
	input  logic signed [VALUE_WIDTH-1:0] rho_s5,
	input  logic signed [VALUE_WIDTH-1:0] p_s6,
	input  logic [lbmc_pkg::RATE_W-1:0]   rate,
	input  lbmc_pkg::kind_t               kind_s10,
	input  lbmc_pkg::kind_t               kind_s11,
	output logic signed [VALUE_WIDTH-1:0] lo_s12,
	output logic signed [VALUE_WIDTH-1:0] hi_s12
);
	localparam longint W18 = ((64'sd1 <<< FRAC_BITS) + 9) / 18;
	localparam longint W36 = ((64'sd1 <<< FRAC_BITS) + 18) / 36;
	localparam logic signed [32:0] W_K  = 33'((AXIS != 0) ? W18 : W36);
	localparam logic signed [32:0] K45  = 33'(64'sd9 <<< (FRAC_BITS - 1));

	logic signed [VALUE_WIDTH-1:0] fp_s [2:11];
	logic signed [VALUE_WIDTH-1:0] fn_s [2:11];
	logic signed [VALUE_WIDTH-1:0] c_s [4:6];
	logic signed [VALUE_WIDTH-1:0] t_s [6:11];
	logic signed [VALUE_WIDTH-1:0] epos_s [8:10];
	logic signed [VALUE_WIDTH-1:0] eneg_s [8:10];
	logic signed [VALUE_WIDTH-1:0] gc_s4, c2_s5, gw_s5, h_s6, ap_s7, an_s7;
	logic signed [VALUE_WIDTH-1:0] dp_s9, dn_s9, mp_s10, mn_s10, np_s11, nn_s11;
	logic signed [32:0] rate_k;
	logic signed [63:0] c_nx, gc_nx, c2_nx, gw_nx, h_nx, t_nx, ap_nx, an_nx;
	logic signed [63:0] epos_nx, eneg_nx, dp_nx, dn_nx, mp_nx, mn_nx, np_nx, nn_nx;
	logic signed [63:0] lo_nx, hi_nx;

	assign rate_k = $signed({3'b000, rate});

	always_comb begin
		c_nx  = lbmc_pkg::sat(lbmc_pkg::term(EX, 64'(vx_s3)) + lbmc_pkg::term(EY, 64'(vy_s3))
			+ lbmc_pkg::term(EZ, 64'(vz_s3)), VALUE_WIDTH);
		// the y component of the force enters with its sign flipped
		gc_nx = lbmc_pkg::sat(lbmc_pkg::term(EX, 64'(g0)) - lbmc_pkg::term(EY, 64'(g1))
			+ lbmc_pkg::term(EZ, 64'(g2)), VALUE_WIDTH);
		c2_nx = lbmc_pkg::fmul(33'(c_s[4]), 33'(c_s[4]), FRAC_BITS, VALUE_WIDTH);
		gw_nx = lbmc_pkg::fmul(33'(gc_s4), W_K, FRAC_BITS, VALUE_WIDTH);
		h_nx  = lbmc_pkg::fmul(33'(c2_s5), K45, FRAC_BITS, VALUE_WIDTH);
		t_nx  = lbmc_pkg::fmul(33'(gw_s5), 33'(rho_s5), FRAC_BITS, VALUE_WIDTH);
		ap_nx = lbmc_pkg::sat(64'(p_s6) + 64'sd3 * 64'(c_s[6]) + 64'(h_s6), VALUE_WIDTH);
		an_nx = lbmc_pkg::sat(64'(p_s6) - 64'sd3 * 64'(c_s[6]) + 64'(h_s6), VALUE_WIDTH);
		epos_nx = lbmc_pkg::fmul(W_K, 33'(ap_s7), FRAC_BITS, VALUE_WIDTH);
		eneg_nx = lbmc_pkg::fmul(W_K, 33'(an_s7), FRAC_BITS, VALUE_WIDTH);
		dp_nx = lbmc_pkg::sat(64'(epos_s[8]) - 64'(fp_s[8]), VALUE_WIDTH);
		dn_nx = lbmc_pkg::sat(64'(eneg_s[8]) - 64'(fn_s[8]), VALUE_WIDTH);
		mp_nx = lbmc_pkg::fmul(rate_k, 33'(dp_s9), FRAC_BITS, VALUE_WIDTH);
		mn_nx = lbmc_pkg::fmul(rate_k, 33'(dn_s9), FRAC_BITS, VALUE_WIDTH);
		if (kind_s10 == lbmc_pkg::KIND_FLUID) begin
			np_nx = lbmc_pkg::sat(64'(fp_s[10]) + 64'(mp_s10), VALUE_WIDTH);
			nn_nx = lbmc_pkg::sat(64'(fn_s[10]) + 64'(mn_s10), VALUE_WIDTH);
		end else begin
			np_nx = 64'(epos_s[10]);
			nn_nx = 64'(eneg_s[10]);
		end
		// opposite directions are written back swapped, but obstacle cells keep them in place
		if (kind_s11 == lbmc_pkg::KIND_OBSTACLE) begin
			lo_nx = 64'(fp_s[11]);
			hi_nx = 64'(fn_s[11]);
		end else begin
			lo_nx = lbmc_pkg::sat(64'(nn_s11) - 64'(t_s[11]), VALUE_WIDTH);
			hi_nx = lbmc_pkg::sat(64'(np_s11) + 64'(t_s[11]), VALUE_WIDTH);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			fp_s[2] <= fp_s1;
			fn_s[2] <= fn_s1;
		end
		for (int s = 3; s <= 11; s++)
			if (en[s]) begin
				fp_s[s] <= fp_s[s-1];
				fn_s[s] <= fn_s[s-1];
			end
		if (en[4]) begin
			c_s[4] <= c_nx[VALUE_WIDTH-1:0];
			gc_s4  <= gc_nx[VALUE_WIDTH-1:0];
		end
		if (en[5]) begin
			c_s[5] <= c_s[4];
			c2_s5  <= c2_nx[VALUE_WIDTH-1:0];
			gw_s5  <= gw_nx[VALUE_WIDTH-1:0];
		end
		if (en[6]) begin
			c_s[6] <= c_s[5];
			h_s6   <= h_nx[VALUE_WIDTH-1:0];
			t_s[6] <= t_nx[VALUE_WIDTH-1:0];
		end
		for (int s = 7; s <= 11; s++)
			if (en[s])
				t_s[s] <= t_s[s-1];
		if (en[7]) begin
			ap_s7 <= ap_nx[VALUE_WIDTH-1:0];
			an_s7 <= an_nx[VALUE_WIDTH-1:0];
		end
		if (en[8]) begin
			epos_s[8] <= epos_nx[VALUE_WIDTH-1:0];
			eneg_s[8] <= eneg_nx[VALUE_WIDTH-1:0];
		end
		for (int s = 9; s <= 10; s++)
			if (en[s]) begin
				epos_s[s] <= epos_s[s-1];
				eneg_s[s] <= eneg_s[s-1];
			end
		if (en[9]) begin
			dp_s9 <= dp_nx[VALUE_WIDTH-1:0];
			dn_s9 <= dn_nx[VALUE_WIDTH-1:0];
		end
		if (en[10]) begin
			mp_s10 <= mp_nx[VALUE_WIDTH-1:0];
			mn_s10 <= mn_nx[VALUE_WIDTH-1:0];
		end
		if (en[11]) begin
			np_s11 <= np_nx[VALUE_WIDTH-1:0];
			nn_s11 <= nn_nx[VALUE_WIDTH-1:0];
		end
		if (en[12]) begin
			lo_s12 <= lo_nx[VALUE_WIDTH-1:0];
			hi_s12 <= hi_nx[VALUE_WIDTH-1:0];
		end
	end

endmodule

@@ design/lattice_boltzmann_d3q19_cell_collide.sv @@
// D3Q19 BGK collision for one lattice cell per transaction. The block is a
// 12-stage pipeline and takes a new cell every cycle while the output side
// keeps up, and each stage stalls only when the stage behind it is full. Nine
// pair lanes and a rest-direction lane work on the cell side by side after the
// moment sums; the latency is set by the chain of rounded multiplies in the
// pair lanes.
// Ghost cells are accepted and produce no result. Configuration writes take
// effect at once and must only be made while no cell is in flight.
`include "lattice_boltzmann_d3q19_cell_collide_defines.svh"

module lattice_boltzmann_d3q19_cell_collide #(
	parameter int VALUE_WIDTH = lbmc_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = lbmc_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lbmc_pkg::IDX_W-1:0]       cfg_index,
	input  logic [lbmc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       cell_kind,
	input  logic [63:0]                      slots_0_1,
	input  logic [63:0]                      slots_2_3,
	input  logic [63:0]                      slots_4_5,
	input  logic [63:0]                      slots_6_7,
	input  logic [63:0]                      slots_8_9,
	input  logic [63:0]                      slots_10_11,
	input  logic [63:0]                      slots_12_13,
	input  logic [63:0]                      slots_14_15,
	input  logic [63:0]                      slots_16_17,
	input  logic signed [31:0]               slot_18,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [63:0]                      out_0_1,
	output logic [63:0]                      out_2_3,
	output logic [63:0]                      out_4_5,
	output logic [63:0]                      out_6_7,
	output logic [63:0]                      out_8_9,
	output logic [63:0]                      out_10_11,
	output logic [63:0]                      out_12_13,
	output logic [63:0]                      out_14_15,
	output logic [63:0]                      out_16_17,
	output logic signed [31:0]               out_18,
	output logic [63:0]                      speed_xy,
	output logic [63:0]                      speed_z_rho
);
	localparam int ST = lbmc_pkg::STAGES;
	localparam int NP = lbmc_pkg::NUM_PAIRS;

	logic [lbmc_pkg::RATE_W-1:0] relax_q;
	logic signed [31:0]          drive_q, grav_x_q, grav_y_q, grav_z_q;
	logic                        keep_rho_q, keep_speed_q;

	lbmc_pkg::stage_vec_t en, v_s;
	lbmc_pkg::kind_t      kind_s [1:ST-1];
	logic [63:0]          slot_pairs [NP];
	logic signed [VALUE_WIDTH-1:0] f_s1 [lbmc_pkg::NUM_DIRS];
	logic signed [VALUE_WIDTH-1:0] drive_v, g0, g1, g2;
	logic signed [63:0]            drive_w, g0_w, g1_w, g2_w;
	logic signed [VALUE_WIDTH-1:0] rho_s3, vx_s3, vy_s3, vz_s3, p_s6, rest_s12;
	logic signed [VALUE_WIDTH-1:0] rho_s [4:ST];
	logic signed [VALUE_WIDTH-1:0] vx_s [4:ST];
	logic signed [VALUE_WIDTH-1:0] vy_s [4:ST];
	logic signed [VALUE_WIDTH-1:0] vz_s [4:ST];
	logic signed [VALUE_WIDTH-1:0] lo_s12 [NP];
	logic signed [VALUE_WIDTH-1:0] hi_s12 [NP];
	logic [63:0]                   pair_out [NP];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q      <= lbmc_pkg::RATE_W'(64'd1 << FRAC_BITS);
			drive_q      <= '0;
			grav_x_q     <= '0;
			grav_y_q     <= '0;
			grav_z_q     <= '0;
			keep_rho_q   <= 1'b1;
			keep_speed_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbmc_pkg::REG_RELAX:      relax_q      <= cfg_data[lbmc_pkg::RATE_W-1:0];
				lbmc_pkg::REG_DRIVE:      drive_q      <= cfg_data;
				lbmc_pkg::REG_GRAV_X:     grav_x_q     <= cfg_data;
				lbmc_pkg::REG_GRAV_Y:     grav_y_q     <= cfg_data;
				lbmc_pkg::REG_GRAV_Z:     grav_z_q     <= cfg_data;
				lbmc_pkg::REG_KEEP_RHO:   keep_rho_q   <= cfg_data[0];
				lbmc_pkg::REG_KEEP_SPEED: keep_speed_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		drive_w = lbmc_pkg::sat(64'(drive_q), VALUE_WIDTH);
		g0_w    = lbmc_pkg::sat(64'(grav_x_q), VALUE_WIDTH);
		g1_w    = lbmc_pkg::sat(64'(grav_y_q), VALUE_WIDTH);
		g2_w    = lbmc_pkg::sat(64'(grav_z_q), VALUE_WIDTH);
	end
	assign drive_v = drive_w[VALUE_WIDTH-1:0];
	assign g0      = g0_w[VALUE_WIDTH-1:0];
	assign g1      = g1_w[VALUE_WIDTH-1:0];
	assign g2      = g2_w[VALUE_WIDTH-1:0];

	// stage flow control: a stage loads when empty or when it drains
	always_comb begin
		en[ST] = !v_s[ST] || out_ready;
		for (int s = ST - 1; s >= 1; s--)
			en[s] = !v_s[s] || en[s+1];
	end
	assign in_ready  = en[1];
	assign out_valid = v_s[ST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1])
				v_s[1] <= in_valid && (lbmc_pkg::kind_t'(cell_kind) != lbmc_pkg::KIND_GHOST);
			for (int s = 2; s <= ST; s++)
				if (en[s])
					v_s[s] <= v_s[s-1];
		end
	end

	assign slot_pairs = '{slots_0_1, slots_2_3, slots_4_5, slots_6_7, slots_8_9,
		slots_10_11, slots_12_13, slots_14_15, slots_16_17};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < NP; k++) begin
				f_s1[2*k]   <= slot_pairs[k][VALUE_WIDTH-1:0];
				f_s1[2*k+1] <= slot_pairs[k][lbmc_pkg::LANE_W +: VALUE_WIDTH];
			end
			f_s1[18]  <= slot_18[VALUE_WIDTH-1:0];
			kind_s[1] <= lbmc_pkg::kind_t'(cell_kind);
		end
		for (int s = 2; s <= ST - 1; s++)
			if (en[s])
				kind_s[s] <= kind_s[s-1];
		if (en[4]) begin
			rho_s[4] <= rho_s3;
			vx_s[4]  <= vx_s3;
			vy_s[4]  <= vy_s3;
			vz_s[4]  <= vz_s3;
		end
		for (int s = 5; s <= ST - 1; s++)
			if (en[s]) begin
				rho_s[s] <= rho_s[s-1];
				vx_s[s]  <= vx_s[s-1];
				vy_s[s]  <= vy_s[s-1];
				vz_s[s]  <= vz_s[s-1];
			end
		if (en[ST]) begin
			rho_s[ST] <= keep_rho_q ? rho_s[ST-1] : '0;
			vx_s[ST]  <= keep_speed_q ? vx_s[ST-1] : '0;
			vy_s[ST]  <= keep_speed_q ? vy_s[ST-1] : '0;
			vz_s[ST]  <= keep_speed_q ? vz_s[ST-1] : '0;
		end
	end

	lbmc_moments #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_moments (
		.clk    (clk),
		.en     (en),
		.f_s1   (f_s1),
		.kind_s2(kind_s[2]),
		.drive  (drive_v),
		.rho_s3 (rho_s3),
		.vx_s3  (vx_s3),
		.vy_s3  (vy_s3),
		.vz_s3  (vz_s3)
	);

	lbmc_rest #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_rest (
		.clk     (clk),
		.en      (en),
		.f18_s1  (f_s1[18]),
		.vx_s3   (vx_s3),
		.vy_s3   (vy_s3),
		.vz_s3   (vz_s3),
		.rho_s5  (rho_s[5]),
		.rate    (relax_q),
		.kind_s9 (kind_s[9]),
		.p_s6    (p_s6),
		.rest_s12(rest_s12)
	);

	for (genvar k = 0; k < NP; k++) begin : g_pair
		lbmc_pair #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.FRAC_BITS  (FRAC_BITS),
			.EX         (lbmc_pkg::DIR_X[k]),
			.EY         (lbmc_pkg::DIR_Y[k]),
			.EZ         (lbmc_pkg::DIR_Z[k]),
			.AXIS       (lbmc_pkg::DIR_AXIS[k])
		) u_pair (
			.clk     (clk),
			.en      (en),
			.fp_s1   (f_s1[2*k]),
			.fn_s1   (f_s1[2*k+1]),
			.vx_s3   (vx_s3),
			.vy_s3   (vy_s3),
			.vz_s3   (vz_s3),
			.g0      (g0),
			.g1      (g1),
			.g2      (g2),
			.rho_s5  (rho_s[5]),
			.p_s6    (p_s6),
			.rate    (relax_q),
			.kind_s10(kind_s[10]),
			.kind_s11(kind_s[11]),
			.lo_s12  (lo_s12[k]),
			.hi_s12  (hi_s12[k])
		);
		assign pair_out[k] = {32'(hi_s12[k]), 32'(lo_s12[k])};
	end

	assign out_0_1     = pair_out[0];
	assign out_2_3     = pair_out[1];
	assign out_4_5     = pair_out[2];
	assign out_6_7     = pair_out[3];
	assign out_8_9     = pair_out[4];
	assign out_10_11   = pair_out[5];
	assign out_12_13   = pair_out[6];
	assign out_14_15   = pair_out[7];
	assign out_16_17   = pair_out[8];
	assign out_18      = 32'(rest_s12);
	assign speed_xy    = {32'(vy_s[ST]), 32'(vx_s[ST])};
	assign speed_z_rho = {32'(rho_s[ST]), 32'(vz_s[ST])};

	`LBMC_ASSERT_NEXT(a_cell_enters, in_valid && in_ready && (cell_kind != lbmc_pkg::KIND_GHOST), v_s[1], "accepted cell did not enter the pipeline")
	`LBMC_ASSERT_NEXT(a_ghost_dropped, in_valid && in_ready && (cell_kind == lbmc_pkg::KIND_GHOST), !v_s[1], "ghost cell entered the pipeline")
	`LBMC_ASSERT_NEXT(a_relax_write, cfg_we && (cfg_index == lbmc_pkg::REG_RELAX), relax_q == $past(cfg_data[lbmc_pkg::RATE_W-1:0]), "relax rate write lost")
	`LBMC_ASSERT_NOW(a_full_stalls, v_s[ST] && !out_ready && v_s[ST-1], !en[ST-1], "full stage overwritten while output stalled")

endmodule
